// File: design/htsd_pkg.sv
// Shared definitions for the Huffman tree string decoder.
// Node entry layout, opcodes, register indexes, reset values and walk states.
// No dependencies.
package htsd_pkg;

    localparam int MAX_NODES_DEF = 256;

    localparam int SYM_W   = 8;
    localparam int IDX_W   = 8;
    localparam int COUNT_W = 9;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 9'd256;
    localparam logic [SYM_W-1:0]   TERM_SYM_RST   = 8'd124;   // '|'
    localparam logic [IDX_W-1:0]   LEAF_MARK      = 8'hFF;

    // input item kind, carried in tuser
    localparam logic OP_WRITE_NODE = 1'b0;
    localparam logic OP_DECODE     = 1'b1;

    // configuration register indexes
    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_TERM_SYM   = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] right;
        logic [IDX_W-1:0] left;
        logic [SYM_W-1:0] sym;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CUR,     // entry of the current walk node on the read port
        ST_NXT,     // entry of the child just stepped to on the read port
        ST_FIN      // flush the held result as the last beat of the byte
    } t_state;

endpackage

// File: design/huffman_tree_string_decoder.sv
// Channel   | Dir | Handshake                     | Payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser: operation; tdata: node fields, code
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: symbol; tuser: end; tlast: last
// cfg       | in  | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// A node write goes straight to the table from idle. A decode byte walks each coded bit through
// the current node's entry, then the child's, each behind the registered table read; a leaf
// already at the walk position spends its bit at the current node. A closing state flushes the
// byte before the input is taken again, so no new decode beat is taken while one is walked.
// Synchronous active-low reset clears control and configuration; the table is not cleared.
// A stalled result port holds the walk at the next symbol; input and config beats are taken
// only when idle, config first.
// Depends on htsd_pkg and htsd_ram.
module huffman_tree_string_decoder
    import htsd_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // node_index, node_symbol, node_left, node_right,
                                         // coded_byte
    input  logic         s_axis_tuser,   // operation
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata,   // symbol
    output logic         m_axis_tuser,   // string_end
    output logic         m_axis_tlast,
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [8:0]   i_cfg_data
);

    localparam int AW = $clog2(MAX_NODES);
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_NODES);

    function automatic logic [IDX_W-1:0] root_of(input logic [COUNT_W-1:0] nc);
        logic [COUNT_W-1:0] r;
        if (nc == '0) begin
            r = '0;
        end else if (nc > MAX_CNT) begin
            r = MAX_CNT - COUNT_W'(1);
        end else begin
            r = nc - COUNT_W'(1);
        end
        return r[IDX_W-1:0];
    endfunction

    function automatic logic beyond_table(input logic [IDX_W-1:0] idx);
        return {1'b0, idx} >= MAX_CNT;
    endfunction

    // input fields
    logic [IDX_W-1:0] in_index;
    t_node            in_node;
    logic [7:0]       in_code;
    assign in_index      = s_axis_tdata[7:0];
    assign in_node.sym   = s_axis_tdata[15:8];
    assign in_node.left  = s_axis_tdata[23:16];
    assign in_node.right = s_axis_tdata[31:24];
    assign in_code       = s_axis_tdata[39:32];

    // state
    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_node_count;
    logic [SYM_W-1:0]   r_term;
    logic [IDX_W-1:0]   r_walk, n_walk;
    logic [7:0]         r_bits, n_bits;
    logic [2:0]         r_count, n_count;
    logic               r_oob, n_oob;
    logic               r_pend_v, n_pend_v;
    logic [SYM_W-1:0]   r_pend_sym, n_pend_sym;
    logic               r_pend_end, n_pend_end;
    logic               r_m_valid;
    logic [SYM_W-1:0]   r_m_sym;
    logic               r_m_end;
    logic               r_m_last;

    // node table
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [NODE_W-1:0] ram_rd_data;

    htsd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_node_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (in_node),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    logic             s_acc, cfg_acc, out_free;
    t_node            node;
    logic             is_leaf, ends;
    logic             do_emit, emitted, bit_done;
    logic [IDX_W-1:0] child;
    logic             push, push_last;
    logic [SYM_W-1:0] push_sym;
    logic             push_end;

    // config never lands mid-walk; a pending config beat holds off the input
    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign out_free      = !r_m_valid || m_axis_tready;

    always_comb begin
        node    = r_oob ? t_node'('0) : t_node'(ram_rd_data);
        is_leaf = (node.left == LEAF_MARK);
        ends    = (node.sym == r_term);
        child   = r_bits[7] ? node.right : node.left;

        n_state    = r_state;
        n_walk     = r_walk;
        n_bits     = r_bits;
        n_count    = r_count;
        n_oob      = r_oob;
        n_pend_v   = r_pend_v;
        n_pend_sym = r_pend_sym;
        n_pend_end = r_pend_end;
        ram_wr_en   = 1'b0;
        ram_wr_addr = in_index[AW-1:0];
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_walk[AW-1:0];
        do_emit   = 1'b0;
        emitted   = 1'b0;
        bit_done  = 1'b0;
        push      = 1'b0;
        push_last = 1'b0;
        push_sym  = r_pend_sym;
        push_end  = r_pend_end;

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_axis_tuser == OP_WRITE_NODE) begin
                        ram_wr_en = !beyond_table(in_index);
                    end else begin
                        n_bits    = in_code;
                        n_count   = '0;
                        ram_rd_en = 1'b1;
                        n_oob     = beyond_table(r_walk);
                        n_state   = ST_CUR;
                    end
                end
                if (cfg_acc && i_cfg_index == CFG_NODE_COUNT) begin
                    n_walk = root_of(i_cfg_data);
                end
            end
            ST_CUR: begin
                if (is_leaf) begin
                    do_emit = 1'b1;
                end else begin
                    n_walk      = child;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = child[AW-1:0];
                    n_oob       = beyond_table(child);
                    n_state     = ST_NXT;
                end
            end
            ST_NXT: begin
                if (is_leaf) begin
                    do_emit = 1'b1;
                end else begin
                    // child is the walk node for the next bit; its entry stays on the port
                    bit_done = 1'b1;
                end
            end
            ST_FIN: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_pend_v  = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // a new symbol displaces the held one, which is then known not to be last
        if (do_emit && (!r_pend_v || out_free)) begin
            push       = r_pend_v;
            n_pend_v   = 1'b1;
            n_pend_sym = node.sym;
            n_pend_end = ends;
            n_walk     = root_of(r_node_count);
            emitted    = 1'b1;
            bit_done   = 1'b1;
        end

        if (bit_done) begin
            n_bits  = {r_bits[6:0], 1'b0};
            n_count = r_count + 3'd1;
            if ((emitted && ends) || r_count == 3'd7) begin
                n_state = ST_FIN;
            end else if (emitted) begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = n_walk[AW-1:0];
                n_oob       = 1'b0;
                n_state     = ST_CUR;
            end else begin
                n_state = ST_CUR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node_count <= NODE_COUNT_RST;
            r_term       <= TERM_SYM_RST;
            r_walk       <= root_of(NODE_COUNT_RST);
            r_count      <= '0;
            r_oob        <= 1'b0;
            r_pend_v     <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_walk   <= n_walk;
            r_count  <= n_count;
            r_oob    <= n_oob;
            r_pend_v <= n_pend_v;
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                    CFG_TERM_SYM:   r_term       <= i_cfg_data[SYM_W-1:0];
                    default:        r_term       <= r_term;
                endcase
            end
            if (push) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits     <= n_bits;
        r_pend_sym <= n_pend_sym;
        r_pend_end <= n_pend_end;
        if (push) begin
            r_m_sym  <= push_sym;
            r_m_end  <= push_end;
            r_m_last <= push_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_sym;
    assign m_axis_tuser  = r_m_end;
    assign m_axis_tlast  = r_m_last;

`ifndef SYNTH
    a_idle_nothing_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("held result left behind in idle");

    a_term_closes_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_v && r_pend_end) |-> (r_state == ST_FIN))
        else $error("walk continued after string end");

    a_end_beat_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("string end beat not flagged last");
`endif

endmodule

// File: design/htsd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module htsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: verif/huffman_tree_string_decoder_test.sv
// Self-checking bench for huffman_tree_string_decoder: node loads, coded bytes, config writes.
// A scoreboard class walks its own copy of the node table; result beats are checked in order.
// Depends on htsd_pkg and the decoder RTL.
module huffman_tree_string_decoder_test
    import htsd_pkg::*;
();

    typedef struct packed {
        logic [7:0] symbol;
        logic       string_end;
        logic       last;
    } t_sym_beat;

    typedef struct packed {
        logic       op;
        logic [7:0] index;
        logic [7:0] sym;
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] code;
    } t_dec_req;

    class huff_walk_model;
        t_node      nodes [256];
        logic [8:0] node_count;
        logic [7:0] term_sym;
        logic [7:0] walk_at;
        t_sym_beat  expected_syms [$];
        int         mismatches;

        function new();
            foreach (nodes[i]) nodes[i] = '0;
            node_count = NODE_COUNT_RST;
            term_sym   = TERM_SYM_RST;
            walk_at    = root_node();
            mismatches = 0;
        endfunction

        function logic [7:0] root_node();
            if (node_count == 9'd0) return 8'd0;
            if (node_count > 9'd256) return 8'd255;
            return 8'(node_count - 9'd1);
        endfunction

        function void set_register(logic idx, logic [8:0] val);
            if (idx == CFG_NODE_COUNT) begin
                node_count = val;
                walk_at    = root_node();
            end else begin
                term_sym = val[7:0];
            end
        endfunction

        // one accepted input beat: load a node or walk eight coded bits
        function void note_item(t_dec_req it);
            t_node      cur;
            logic [7:0] bits;
            logic       hit;
            int         first;
            t_sym_beat  beat;
            if (it.op == OP_WRITE_NODE) begin
                nodes[it.index] = '{right: it.right, left: it.left, sym: it.sym};
                return;
            end
            first = expected_syms.size();
            bits  = it.code;
            for (int b = 0; b < 8; b++) begin
                cur = nodes[walk_at];
                hit = (cur.left == LEAF_MARK);
                // a leaf sitting at the walk position spends the bit without stepping
                if (!hit) begin
                    walk_at = bits[7] ? cur.right : cur.left;
                    cur     = nodes[walk_at];
                    hit     = (cur.left == LEAF_MARK);
                end
                bits = bits << 1;
                if (hit) begin
                    beat = '{symbol: cur.sym, string_end: (cur.sym == term_sym), last: 1'b0};
                    expected_syms.insert(expected_syms.size(), beat);
                    walk_at = root_node();
                    if (cur.sym == term_sym) break;
                end
            end
            if (expected_syms.size() > first) begin
                beat      = expected_syms[expected_syms.size() - 1];
                beat.last = 1'b1;
                expected_syms[expected_syms.size() - 1] = beat;
            end
        endfunction

        function void check_symbol(logic [7:0] symbol, logic string_end, logic last);
            t_sym_beat want;
            if (expected_syms.size() == 0) begin
                $display("%0t: unexpected beat symbol=%02h end=%b last=%b",
                         $time, symbol, string_end, last);
                mismatches++;
                return;
            end
            want = expected_syms.pop_front();
            if (symbol !== want.symbol) begin
                $display("%0t: symbol expected %02h actual %02h", $time, want.symbol, symbol);
                mismatches++;
            end
            if (string_end !== want.string_end) begin
                $display("%0t: string_end expected %b actual %b",
                         $time, want.string_end, string_end);
                mismatches++;
            end
            if (last !== want.last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [8:0]  i_cfg_data = '0;

    huff_walk_model walker;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_armed = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    // table entries loaded so far; links are only ever drawn from these
    bit   written [256];
    int   written_list [$];

    huffman_tree_string_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: check each beat, then pick tready for the next cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                walker.check_symbol(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (hold_armed && !hold_done) begin
                // long back-pressure so the decoder fills and stalls its input
                hold_left     <= 300;
                hold_done     <= 1'b1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic offer_item(input t_dec_req it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {it.code, it.right, it.left, it.sym, it.index};
        do @(posedge i_clk); while (!s_axis_tready);
        walker.note_item(it);
    endtask

    task automatic rest_sender();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (walker.expected_syms.size() != 0) @(posedge i_clk);
        // a walk that ends without a symbol may still be running
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [8:0] count, input logic [7:0] term);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_NODE_COUNT;
        i_cfg_data  <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        walker.set_register(CFG_NODE_COUNT, count);
        i_cfg_index <= CFG_TERM_SYM;
        i_cfg_data  <= {1'b0, term};
        do @(posedge i_clk); while (!o_cfg_ready);
        walker.set_register(CFG_TERM_SYM, {1'b0, term});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_node(input logic [7:0] idx, input logic [7:0] sym,
                              input logic [7:0] left, input logic [7:0] right);
        t_dec_req it;
        it = '{op: OP_WRITE_NODE, index: idx, sym: sym, left: left, right: right,
               code: 8'($urandom_range(255))};
        offer_item(it);
        if (!written[idx]) begin
            written[idx] = 1'b1;
            written_list.insert(written_list.size(), int'(idx));
        end
    endtask

    task automatic decode_byte(input logic [7:0] code);
        t_dec_req it;
        it = '{op: OP_DECODE, index: 8'($urandom_range(255)), sym: 8'($urandom_range(255)),
               left: 8'($urandom_range(255)), right: 8'($urandom_range(255)), code: code};
        offer_item(it);
    endtask

    // overwrite a random entry, keeping every link on a loaded entry
    task automatic scramble_node();
        logic [7:0] left;
        logic [7:0] right;
        int         v;
        if ($urandom_range(99) < 40) begin
            left  = LEAF_MARK;
            right = 8'($urandom_range(255));
        end else begin
            do v = written_list[$urandom_range(written_list.size() - 1)]; while (v == 255);
            left  = 8'(v);
            right = 8'(written_list[$urandom_range(written_list.size() - 1)]);
        end
        write_node(8'($urandom_range(255)), 8'($urandom_range(255)), left, right);
    endtask

    // random full binary tree on scattered entries, children loaded before parents
    task automatic build_tree(input logic [7:0] root, input int leaves,
                              input logic [7:0] pin_sym);
        int         kid_l [16];
        int         kid_r [16];
        bit         is_leaf [16];
        logic [7:0] at [16];
        int         n;
        int         j;
        bit         dup;
        logic [7:0] sym;
        n          = 1;
        is_leaf[0] = 1'b1;
        for (int s = 1; s < leaves; s++) begin
            do j = $urandom_range(n - 1); while (!is_leaf[j]);
            kid_l[j]     = n;
            kid_r[j]     = n + 1;
            is_leaf[j]   = 1'b0;
            is_leaf[n]   = 1'b1;
            is_leaf[n+1] = 1'b1;
            n += 2;
        end
        at[0] = root;
        for (int id = 1; id < n; id++) begin
            // 255 is kept off child links, it would read as the leaf mark
            do begin
                at[id] = 8'($urandom_range(254));
                dup    = 1'b0;
                for (int k = 0; k < id; k++)
                    if (at[k] == at[id]) dup = 1'b1;
            end while (dup);
        end
        for (int id = n - 1; id >= 0; id--) begin
            sym = ($urandom_range(3) == 0) ? pin_sym : 8'($urandom_range(255));
            if (is_leaf[id])
                write_node(at[id], sym, LEAF_MARK, 8'($urandom_range(255)));
            else
                write_node(at[id], sym, at[kid_l[id]], at[kid_r[id]]);
        end
    endtask

    initial begin
        int         count;
        logic [7:0] term;
        int         leaves;
        walker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 31;
        recv_idle_pct = 77;

        // reset config: root 255, terminator '|'; codes A=0, '|'=10, FF=11
        write_node(8'd0,   8'h41, LEAF_MARK, 8'h00);
        write_node(8'd1,   8'h00, 8'd2, 8'd3);
        write_node(8'd2,   8'h7C, LEAF_MARK, 8'hFF);
        write_node(8'd3,   8'hFF, LEAF_MARK, 8'h55);
        write_node(8'd255, 8'h00, 8'd0, 8'd1);
        decode_byte(8'h00);     // eight symbols from one byte
        decode_byte(8'hFF);
        decode_byte(8'h6C);
        decode_byte(8'h01);     // ends mid-code, walk carries over
        decode_byte(8'h00);     // terminator first, rest dropped
        decode_byte(8'h40);
        decode_byte(8'h80);

        // root is itself a leaf: every bit emits it, up to the terminator
        rest_sender();
        wait_drained();
        set_config(9'd1, 8'h7C);
        decode_byte(8'hA5);
        rest_sender();
        wait_drained();
        set_config(9'd1, 8'h41);
        decode_byte(8'h3C);

        // root loops on itself: a byte with no symbol at all
        rest_sender();
        wait_drained();
        set_config(9'd6, 8'h00);
        write_node(8'd5, 8'h00, 8'd5, 8'd0);
        decode_byte(8'h00);
        decode_byte(8'h80);

        rest_sender();
        wait_drained();
        set_config(9'd4, 8'hFF);
        decode_byte(8'h12);

        for (int p = 0; p < 9; p++) begin
            rest_sender();
            wait_drained();
            send_idle_pct = (p < 3) ? 31 : (p < 6) ? 77 : 0;
            recv_idle_pct = (p < 3) ? 77 : (p < 6) ? 31 : 0;
            count = (p == 0) ? 256 : (p == 1) ? 1 : $urandom_range(2, 256);
            term  = (p == 2) ? 8'h00 : (p == 3) ? 8'hFF : 8'($urandom_range(255));
            set_config(9'(count), term);
            leaves = (p == 5 || $urandom_range(7) == 0) ? 1 : $urandom_range(2, 8);
            build_tree(8'(count - 1), leaves, term);
            if (p == 4) hold_armed <= 1'b1;
            for (int i = 0; i < 45; i++) begin
                if (p == 7 && i == 22) begin
                    rest_sender();
                    wait_drained();
                end
                if ($urandom_range(99) < 15)
                    scramble_node();
                else
                    decode_byte(8'($urandom_range(255)));
            end
        end

        rest_sender();
        wait_drained();
        if (walker.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

// File: sim.f
design/htsd_pkg.sv
design/htsd_ram.sv
design/huffman_tree_string_decoder.sv
verif/huffman_tree_string_decoder_test.sv
